### rtl/core/wmb_pkg.sv
package wmb_pkg;

  // output coordinate width
  localparam int COORD_W = 10;

  // configuration register indexes (paddr[2])
  localparam logic REG_RESOLUTION = 1'b0;
  localparam logic REG_JADE_CODE  = 1'b1;

  localparam logic [10:0] RESOLUTION_RESET = 11'd256;
  localparam logic [7:0]  JADE_CODE_RESET  = 8'd1;

  localparam logic [7:0] MASK_FULL = 8'd255;
  localparam logic [7:0] MASK_NONE = 8'd0;

  // full kernel weight
  localparam logic [4:0] KERNEL_SUM = 5'd22;

  // floor(255*k/22) for k = 0..22
  localparam logic [7:0] WEIGHT_LUT [0:22] = '{
    8'd0,   8'd11,  8'd23,  8'd34,  8'd46,  8'd57,  8'd69,  8'd81,
    8'd92,  8'd104, 8'd115, 8'd127, 8'd139, 8'd150, 8'd162, 8'd173,
    8'd185, 8'd197, 8'd208, 8'd220, 8'd231, 8'd243, 8'd255
  };

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [7:0]         jade;
    logic [7:0]         junk;
    logic               frame_end;
    logic               last;
  } res_t;

endpackage

### rtl/core/weighted_3x3_class_mask_blur.sv
// path: an accepted word goes through the input stage and then the result
//   queue before its first result reaches the output; a full queue or an
//   output stall can hold it in the input stage
// throughput: one pixel word per cycle while the output is not stalled; a pixel
//   that releases two or three results holds the input while the queue drains
// reset: synchronous, clears counters, window, pipeline and queue and loads
//   resolution 256 and jade code 1; line buffer contents stay undefined
module weighted_3x3_class_mask_blur #(
  parameter int MAX_RES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  class_code,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_col,
  output logic [9:0]  out_row,
  output logic [7:0]  jade_weight,
  output logic [7:0]  junk_weight,
  output logic        frame_end,
  output logic        last,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import wmb_pkg::*;

  // counter width and a width that can hold the side length itself
  localparam int CW   = $clog2(MAX_RES);
  localparam int RW   = CW + 1;
  localparam int CMPW = (RW > 11) ? RW : 11;

  // ---------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------
  logic [10:0] resolution;
  logic [7:0]  jade_code;
  logic        cfg_wr;
  logic        res_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign res_wr = cfg_wr && (paddr[2] == REG_RESOLUTION);

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= RESOLUTION_RESET;
      jade_code  <= JADE_CODE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_RESOLUTION: resolution <= pwdata[10:0];
        REG_JADE_CODE:  jade_code  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RESOLUTION: prdata = {21'd0, resolution};
      REG_JADE_CODE:  prdata = {24'd0, jade_code};
      default:        prdata = '0;
    endcase
  end

  // effective side length: zero acts as one, anything past MAX_RES is clipped
  logic [CMPW-1:0] res_ext;
  logic [RW-1:0]   r_eff;
  logic [CW-1:0]   rm1;

  assign res_ext = CMPW'(resolution);

  always_comb begin
    if (res_ext == '0) begin
      r_eff = RW'(1);
    end else if (res_ext > CMPW'(MAX_RES)) begin
      r_eff = RW'(MAX_RES);
    end else begin
      r_eff = RW'(res_ext);
    end
  end

  assign rm1 = CW'(r_eff - RW'(1));

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  logic       in_acc;
  logic       out_acc;
  logic       a_valid;
  logic       a_move;
  logic [1:0] cnt;

  assign out_valid = (cnt != 2'd0);
  assign out_acc   = out_valid && !out_stall;
  // the input stage hands over only when the queue is empty or about to be
  assign a_move    = a_valid && ((cnt == 2'd0) || ((cnt == 2'd1) && out_acc));
  assign in_stall  = a_valid && !a_move;
  assign in_acc    = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // raster position
  // ---------------------------------------------------------------------
  logic [CW-1:0] col_cnt;
  logic [CW-1:0] row_cnt;
  logic [CW-1:0] c_cur;
  logic [CW-1:0] r_cur;

  // guard against a position left past the frame edge
  assign c_cur = (RW'(col_cnt) >= r_eff) ? '0 : col_cnt;
  assign r_cur = (RW'(row_cnt) >= r_eff) ? '0 : row_cnt;

  always_ff @(posedge clk) begin
    if (rst || res_wr) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_acc) begin
      if (c_cur == rm1) begin
        col_cnt <= '0;
        row_cnt <= (r_cur == rm1) ? '0 : r_cur + CW'(1);
      end else begin
        col_cnt <= c_cur + CW'(1);
        row_cnt <= r_cur;
      end
    end
  end

  // ---------------------------------------------------------------------
  // input stage: jade flag, position and line buffer read
  // ---------------------------------------------------------------------
  logic          a_flag;
  logic [CW-1:0] a_col;
  logic [CW-1:0] a_row;
  logic [1:0]    lb_rd;
  logic          a_above;
  logic          a_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_acc) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_flag <= (class_code == jade_code);
      a_col  <= c_cur;
      a_row  <= r_cur;
    end
  end

  // the column shifts down one row when the stage hands over
  wmb_line_buf #(
    .DEPTH (MAX_RES),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (a_move),
    .wr_addr (a_col),
    .wr_data ({a_above, a_flag}),
    .rd_en   (in_acc),
    .rd_addr (c_cur),
    .rd_data (lb_rd)
  );

  assign a_above = lb_rd[0];
  assign a_two   = lb_rd[1];

  // ---------------------------------------------------------------------
  // 3x3 window: bit = 3*column + row, column 0 oldest, row 0 topmost
  // ---------------------------------------------------------------------
  logic [8:0] window;
  logic [8:0] window_next;

  assign window_next = {a_flag, a_above, a_two, window[8:3]};

  always_ff @(posedge clk) begin
    if (rst || res_wr) begin
      window <= '0;
    end else if (a_move) begin
      window <= window_next;
    end
  end

  // weighted jade count: centre 6, cross 3, diagonals 1
  logic [2:0] cross_n;
  logic [2:0] diag_n;
  logic [4:0] k_sum;

  assign cross_n = 3'(window_next[1]) + 3'(window_next[3])
                 + 3'(window_next[5]) + 3'(window_next[7]);
  assign diag_n  = 3'(window_next[0]) + 3'(window_next[2])
                 + 3'(window_next[6]) + 3'(window_next[8]);
  assign k_sum   = (window_next[4] ? 5'd6 : 5'd0) + 5'(cross_n) * 5'd3 + 5'(diag_n);

  // ---------------------------------------------------------------------
  // up to three results per pixel:
  //   delayed pixel up-left of the current one (filtered when interior)
  //   right-edge pixel of the row above, at the end of a row
  //   the current pixel itself on the bottom row
  // ---------------------------------------------------------------------
  logic [CW-1:0] pr;
  logic [CW-1:0] pc;
  logic          interior;
  logic [2:0]    en;
  logic [7:0]    jade0;
  logic [7:0]    junk0;
  res_t          cand [3];
  res_t          list [3];
  logic [1:0]    n_new;

  assign pr = a_row - CW'(1);
  assign pc = a_col - CW'(1);

  assign interior = (pr != '0) && (pc != '0)
                 && (RW'(pr) + RW'(2) <= r_eff)
                 && (RW'(pc) + RW'(2) <= r_eff);

  assign en[0] = (a_row != '0) && (a_col != '0);
  assign en[1] = (a_row != '0) && (a_col == rm1);
  assign en[2] = (a_row == rm1);

  always_comb begin
    if (interior) begin
      jade0 = WEIGHT_LUT[k_sum];
      junk0 = WEIGHT_LUT[KERNEL_SUM - k_sum];
    end else begin
      jade0 = window_next[4] ? MASK_FULL : MASK_NONE;
      junk0 = window_next[4] ? MASK_NONE : MASK_FULL;
    end
  end

  always_comb begin
    cand[0] = '{col: COORD_W'(pc), row: COORD_W'(pr), jade: jade0, junk: junk0,
                frame_end: 1'b0, last: !en[1] && !en[2]};
    cand[1] = '{col: COORD_W'(a_col), row: COORD_W'(pr),
                jade: a_above ? MASK_FULL : MASK_NONE,
                junk: a_above ? MASK_NONE : MASK_FULL,
                frame_end: 1'b0, last: !en[2]};
    cand[2] = '{col: COORD_W'(a_col), row: COORD_W'(a_row),
                jade: a_flag ? MASK_FULL : MASK_NONE,
                junk: a_flag ? MASK_NONE : MASK_FULL,
                frame_end: (a_col == rm1), last: 1'b1};
  end

  // pack the enabled results in order
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      list[i] = '0;
    end
    n_new = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (en[i]) begin
        list[n_new] = cand[i];
        n_new       = n_new + 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // result queue: loaded whole, drained one word per cycle while out_stall is low, from slot 0
  // ---------------------------------------------------------------------
  res_t slot [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (a_move) begin
      cnt <= n_new;
    end else if (out_acc) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      slot[0] <= list[0];
      slot[1] <= list[1];
      slot[2] <= list[2];
    end else if (out_acc) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign out_col     = slot[0].col;
  assign out_row     = slot[0].row;
  assign jade_weight = slot[0].jade;
  assign junk_weight = slot[0].junk;
  assign frame_end   = slot[0].frame_end;
  assign last        = slot[0].last;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------

  // an accepted pixel sits in the input stage on the next cycle
  a_accept_fills_stage : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> a_valid)
  else $error("accepted pixel did not reach the input stage");

  // a stalled output keeps its queue depth
  a_stall_holds_queue : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(cnt))
  else $error("result queue changed under output stall");

  // the frame's corner pixel closes its burst
  a_frame_end_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> last)
  else $error("frame end result is not the last of its burst");

  // the two mask channels are complementary up to flooring
  a_mask_sum : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((9'(jade_weight) + 9'(junk_weight) == 9'd255) ||
                   (9'(jade_weight) + 9'(junk_weight) == 9'd254)))
  else $error("jade and junk weights do not add up");

endmodule

### rtl/core/wmb_line_buf.sv
module wmb_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data
);

  // bit 0: row above, bit 1: row two above
  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first read so a same-column write in this cycle is seen
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

### verif/tb_weighted_3x3_class_mask_blur.sv
module tb_weighted_3x3_class_mask_blur;
  import wmb_pkg::*;

  localparam int MAX_RES = 1024;
  // weights and mask scale of the blur
  localparam int FULL = 255;
  localparam int KSUM = 22;
  // settle time after the last result before a register write
  localparam int IDLE_TAIL = 8;
  // receiver hold-off long enough to back the block up into its input
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 240;
  // random word count at which the long hold starts
  localparam int HOLD_AT = 40;
  // words sent into the widest frames
  localparam int WIDE_ITEMS = 16;

  // directed rows: register write, predicted pixel, or pixel with a fixed result
  typedef enum {ROW_REG, ROW_PIXEL, ROW_FIXED} row_kind_e;
  typedef struct {
    row_kind_e   kind;
    logic        sel;
    logic [31:0] value;
    res_t        mask;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  class_code = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_col;
  logic [9:0]  out_row;
  logic [7:0]  jade_weight;
  logic [7:0]  junk_weight;
  logic        frame_end;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the block state
  logic [10:0] res_setting = RESOLUTION_RESET;
  logic [7:0]  jade_match = JADE_CODE_RESET;
  bit          above_line [MAX_RES];
  bit          two_above_line [MAX_RES];
  bit [8:0]    win_flags = '0;
  int unsigned next_col = 0;
  int unsigned next_row = 0;

  // masks still owed by the block, oldest first
  res_t pending_masks [$];
  int   mismatch_count = 0;
  bit   calm = 1'b0;
  bit   stall_hold_req = 1'b0;

  stim_row_t dir_rows [35] = '{
    // one-pixel frame (resolution 0 acts as 1): every pixel is its own frame end
    '{ROW_REG,   REG_RESOLUTION, 32'd0,   '0},
    '{ROW_REG,   REG_JADE_CODE,  32'd0,   '0},
    '{ROW_FIXED, 1'b0, 32'd0,   res_t'{10'd0, 10'd0, 8'd255, 8'd0,   1'b1, 1'b1}},
    '{ROW_FIXED, 1'b0, 32'd255, res_t'{10'd0, 10'd0, 8'd0,   8'd255, 1'b1, 1'b1}},
    '{ROW_REG,   REG_RESOLUTION, 32'd1,   '0},
    '{ROW_REG,   REG_JADE_CODE,  32'd255, '0},
    '{ROW_FIXED, 1'b0, 32'd255, res_t'{10'd0, 10'd0, 8'd255, 8'd0,   1'b1, 1'b1}},
    '{ROW_FIXED, 1'b0, 32'd0,   res_t'{10'd0, 10'd0, 8'd0,   8'd255, 1'b1, 1'b1}},
    '{ROW_FIXED, 1'b0, 32'd254, res_t'{10'd0, 10'd0, 8'd0,   8'd255, 1'b1, 1'b1}},
    // two-pixel side: all border, several results from the last word of the last row
    '{ROW_REG,   REG_RESOLUTION, 32'd2,   '0},
    '{ROW_PIXEL, 1'b0, 32'd255, '0},
    '{ROW_PIXEL, 1'b0, 32'd0,   '0},
    '{ROW_PIXEL, 1'b0, 32'd0,   '0},
    '{ROW_PIXEL, 1'b0, 32'd255, '0},
    // three-pixel side, jade code changed mid-frame, all jade gives full weight
    '{ROW_REG,   REG_RESOLUTION, 32'd3,   '0},
    '{ROW_REG,   REG_JADE_CODE,  32'h5a,  '0},
    '{ROW_PIXEL, 1'b0, 32'h5a,  '0},
    '{ROW_PIXEL, 1'b0, 32'h5a,  '0},
    '{ROW_PIXEL, 1'b0, 32'h5a,  '0},
    '{ROW_PIXEL, 1'b0, 32'h5a,  '0},
    '{ROW_PIXEL, 1'b0, 32'h5a,  '0},
    '{ROW_REG,   REG_JADE_CODE,  32'ha5,  '0},
    '{ROW_PIXEL, 1'b0, 32'ha5,  '0},
    '{ROW_PIXEL, 1'b0, 32'ha5,  '0},
    '{ROW_PIXEL, 1'b0, 32'ha5,  '0},
    '{ROW_PIXEL, 1'b0, 32'ha5,  '0},
    // second frame: plus shape of jade around the centre
    '{ROW_PIXEL, 1'b0, 32'h00,  '0},
    '{ROW_PIXEL, 1'b0, 32'ha5,  '0},
    '{ROW_PIXEL, 1'b0, 32'h00,  '0},
    '{ROW_PIXEL, 1'b0, 32'ha5,  '0},
    '{ROW_PIXEL, 1'b0, 32'ha5,  '0},
    '{ROW_PIXEL, 1'b0, 32'ha5,  '0},
    '{ROW_PIXEL, 1'b0, 32'h00,  '0},
    '{ROW_PIXEL, 1'b0, 32'ha5,  '0},
    '{ROW_PIXEL, 1'b0, 32'h00,  '0}
  };

  weighted_3x3_class_mask_blur #(.MAX_RES(MAX_RES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .class_code(class_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_col(out_col), .out_row(out_row),
    .jade_weight(jade_weight), .junk_weight(junk_weight),
    .frame_end(frame_end), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("tb_weighted_3x3_class_mask_blur: done, errors");
    $finish;
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // weighted jade count: centre 6, cross 3, diagonals 1
  function automatic int unsigned kernel_sum(bit [8:0] w);
    return 6 * w[4] + 3 * (w[1] + w[3] + w[5] + w[7]) + w[0] + w[2] + w[6] + w[8];
  endfunction

  function automatic res_t mask_word(int unsigned row, int unsigned col, int unsigned jade,
                                     int unsigned junk, bit fe);
    res_t m;
    m.col = col[9:0];
    m.row = row[9:0];
    m.jade = jade[7:0];
    m.junk = junk[7:0];
    m.frame_end = fe;
    m.last = 1'b0;
    return m;
  endfunction

  // border pixels pass the hard mask through
  function automatic res_t border_word(int unsigned row, int unsigned col, bit flag, bit fe);
    return mask_word(row, col, flag ? FULL : 0, flag ? 0 : FULL, fe);
  endfunction

  // advance the blur state by one pixel, optionally queueing what it releases
  task automatic blur_pixel(input logic [7:0] code, input bit keep);
    int unsigned side;
    int unsigned r;
    int unsigned c;
    int unsigned k;
    bit flag;
    bit above;
    bit two_above;
    res_t made [$];
    side = (res_setting == 0) ? 1 : ((res_setting > MAX_RES) ? MAX_RES : res_setting);
    if (next_col >= side) next_col = 0;
    if (next_row >= side) next_row = 0;
    r = next_row;
    c = next_col;
    flag = (code == jade_match);
    above = above_line[c];
    two_above = two_above_line[c];
    two_above_line[c] = above;
    above_line[c] = flag;
    // newest column enters at the top bits, topmost row in the low bit
    win_flags = {flag, above, two_above, win_flags[8:3]};
    if (r >= 1) begin
      // the window centre is one row up and one column back
      if (c >= 1) begin
        if (r >= 2 && r + 1 <= side && c >= 2 && c + 1 <= side) begin
          k = kernel_sum(win_flags);
          made.push_back(mask_word(r - 1, c - 1, FULL * k / KSUM, FULL * (KSUM - k) / KSUM,
                                   1'b0));
        end else begin
          made.push_back(border_word(r - 1, c - 1, win_flags[4], 1'b0));
        end
      end
      // right border of the row above
      if (c == side - 1) made.push_back(border_word(r - 1, c, above, 1'b0));
    end
    // bottom row goes straight out
    if (r == side - 1) made.push_back(border_word(r, c, flag, c == side - 1));
    if (made.size() != 0) made[made.size() - 1].last = 1'b1;
    if (keep) begin
      foreach (made[i]) pending_masks.push_back(made[i]);
    end
    c++;
    if (c >= side) begin
      c = 0;
      r++;
      if (r >= side) r = 0;
    end
    next_col = c;
    next_row = r;
  endtask

  // mostly jade, some near misses one bit away, the rest anything
  function automatic logic [7:0] pick_code();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return jade_match;
    if (roll < 7) return jade_match ^ (8'd1 << $urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one pixel word, with an occasional idle burst ahead of it
  task automatic send_pixel(input logic [7:0] code, input bit keep);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    class_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    blur_pixel(code, keep);
  endtask

  // stop offering, wait for every owed mask, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // setup cycle then access cycle
  task automatic apb_access(input bit wr, input logic sel, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(input logic sel, input logic [31:0] want);
    logic [31:0] got;
    apb_access(1'b0, sel, 32'd0, got);
    check_field(sel == REG_RESOLUTION ? "resolution readback" : "jade_code readback",
                want, got);
  endtask

  task automatic reg_write(input logic sel, input logic [31:0] value);
    logic [31:0] ignored;
    logic [31:0] want;
    settle();
    apb_access(1'b1, sel, value, ignored);
    if (sel == REG_RESOLUTION) begin
      // a new side length restarts the frame
      res_setting = value[10:0];
      win_flags = '0;
      next_col = 0;
      next_row = 0;
      want = {21'd0, value[10:0]};
    end else begin
      jade_match = value[7:0];
      want = {24'd0, value[7:0]};
    end
    reg_check(sel, want);
  endtask

  // receiver: random stall bursts, one long hold on request, none once calm
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (stall_hold_req) begin
        stall_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare every accepted result word against the oldest owed mask
  always @(posedge clk) begin : score_masks
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_masks.size() == 0) begin
        $display("%0t unexpected word: expected none, got col %0d row %0d",
                 $time, out_col, out_row);
        mismatch_count++;
      end else begin
        want = pending_masks.pop_front();
        check_field("out_col", want.col, out_col);
        check_field("out_row", want.row, out_row);
        check_field("jade_weight", want.jade, jade_weight);
        check_field("junk_weight", want.junk, junk_weight);
        check_field("frame_end", want.frame_end, frame_end);
        check_field("last", want.last, last);
      end
    end
  end

  initial begin : stimulus
    int unsigned random_fed;
    int unsigned side;
    int unsigned res_pick;
    int unsigned count;
    random_fed = 0;
    side = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_check(REG_RESOLUTION, {21'd0, RESOLUTION_RESET});
    reg_check(REG_JADE_CODE, {24'd0, JADE_CODE_RESET});

    // directed rows
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_REG: begin
          reg_write(dir_rows[i].sel, dir_rows[i].value);
        end
        ROW_PIXEL: begin
          send_pixel(dir_rows[i].value[7:0], 1'b1);
        end
        default: begin
          send_pixel(dir_rows[i].value[7:0], 1'b0);
          pending_masks.push_back(dir_rows[i].mask);
        end
      endcase
    end

    // widest frame: a stretch of the top row, which releases nothing yet
    reg_write(REG_RESOLUTION, 32'd1024);
    for (int i = 0; i < WIDE_ITEMS; i++) send_pixel(pick_code(), 1'b1);
    // oversize side clamps to the widest frame
    reg_write(REG_RESOLUTION, 32'd2047);
    for (int i = 0; i < WIDE_ITEMS; i++) send_pixel(pick_code(), 1'b1);

    // random frames, mostly small and whole, some cut short, some jade-only updates
    while (random_fed < RANDOM_ITEMS) begin
      if (random_fed >= RANDOM_ITEMS * 4 / 5) calm = 1'b1;
      if (side != 0 && $urandom_range(0, 4) == 0) begin
        // new jade code mid-frame, frame position kept
        reg_write(REG_JADE_CODE, $urandom_range(0, 255));
        count = $urandom_range(1, 2 * side);
      end else begin
        if ($urandom_range(0, 7) == 0) res_pick = $urandom_range(0, 2);
        else res_pick = $urandom_range(3, 10);
        reg_write(REG_RESOLUTION, res_pick);
        if ($urandom_range(0, 1) == 0) reg_write(REG_JADE_CODE, $urandom_range(0, 255));
        side = (res_pick == 0) ? 1 : res_pick;
        if ($urandom_range(0, 3) == 0) count = $urandom_range(1, side * side);
        else count = side * side * $urandom_range(1, 2);
      end
      if (count > RANDOM_ITEMS - random_fed) count = RANDOM_ITEMS - random_fed;
      repeat (count) begin
        // one long receiver hold while words keep coming
        if (random_fed == HOLD_AT) stall_hold_req = 1'b1;
        send_pixel(pick_code(), 1'b1);
        random_fed++;
      end
    end

    settle();
    repeat (IDLE_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_weighted_3x3_class_mask_blur: done, clean");
    end else begin
      $display("tb_weighted_3x3_class_mask_blur: done, errors");
    end
    $finish;
  end

endmodule
